>>> src/s2gl_pkg.sv
// ----------------------------------------------------------------------------
// s2gl_pkg: shared constants, types and ROM contents for sRGB to gray
// Holds the field widths, the Rec.709 luminance weights and the two lookup
// tables (sRGB linearize, luminance encode), which are built exactly at
// elaboration with wide integer arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

package s2gl_pkg;

  localparam int PIX_W          = 8;
  localparam int LIN_W          = 16;
  localparam int SUM_W          = 2 * LIN_W;
  localparam int LUM_INDEX_BITS = 12;
  localparam int LIN_DEPTH      = 2 ** PIX_W;
  localparam int ENC_DEPTH      = 2 ** LUM_INDEX_BITS;
  localparam int GRAY_MAX       = LIN_DEPTH - 1;

  // Q0.16 Rec.709 weights; they add up to exactly 2^16.
  localparam logic [LIN_W-1:0] R_WEIGHT = 16'd13933;
  localparam logic [LIN_W-1:0] G_WEIGHT = 16'd46871;
  localparam logic [LIN_W-1:0] B_WEIGHT = 16'd4732;

  // Wide integer used only while the tables are built.
  localparam int BN_W = 320;

  // 1.055 * 255 scaled by 1000, and 0.055 * 255 scaled by 1000.
  localparam longint unsigned ENC_DEN   = 64'd269025;
  localparam longint unsigned ENC_OFS   = 64'd14025;
  localparam longint unsigned ENC_STEP  = 64'd1000;
  localparam longint unsigned LIN_MAX   = 64'd65535;
  localparam int              LIN_KNEE  = 10;
  localparam longint unsigned IDX_MAX   = 64'(ENC_DEPTH - 1);
  // Divisor of the encode curve's linear toe: 10 * M.
  localparam longint unsigned ENC_TOE_DEN = 64'd10 * IDX_MAX;

  typedef logic [BN_W-1:0]                     bn_t;
  typedef logic [PIX_W-1:0]                    pix_t;
  typedef logic [LIN_W-1:0]                    lin_t;
  typedef logic [LUM_INDEX_BITS-1:0]           idx_t;
  typedef logic [LIN_DEPTH-1:0][LIN_W-1:0]     lin_tab_t;
  typedef logic [ENC_DEPTH-1:0][PIX_W-1:0]     enc_tab_t;

  function automatic bn_t bn_pow(bn_t base, int unsigned e);
    bn_t acc;
    acc = bn_t'(1);
    for (int unsigned i = 0; i < e; i++) begin
      acc = acc * base;
    end
    return acc;
  endfunction

  // Linearize table: round(65535 * lin(c / 255)). Above the knee the
  // largest y with (2y-1)^5 * den^12 <= 32 * 65535^5 * a^12 is searched.
  function automatic lin_tab_t build_lin_tab();
    lin_tab_t    tab;
    bn_t         den12;
    bn_t         q;
    bn_t         rhs;
    bn_t         lhs;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] mid;
    longint unsigned a;
    den12 = bn_pow(bn_t'(ENC_DEN), 12);
    q     = bn_t'(32) * bn_pow(bn_t'(LIN_MAX), 5);
    for (int c = 0; c < LIN_DEPTH; c++) begin
      if (c <= LIN_KNEE) begin
        tab[c] = LIN_W'((64'd1310700 * 64'(c) + 64'd32946) / 64'd65892);
      end else begin
        a   = ENC_STEP * 64'(c) + ENC_OFS;
        rhs = q * bn_pow(bn_t'(a), 12);
        lo  = 32'd0;
        hi  = 32'(LIN_MAX);
        while (lo < hi) begin
          mid = (lo + hi + 32'd1) >> 1;
          lhs = bn_pow(bn_t'(2 * mid - 32'd1), 5) * den12;
          if (lhs <= rhs) begin
            lo = mid;
          end else begin
            hi = mid - 32'd1;
          end
        end
        tab[c] = LIN_W'(lo);
      end
    end
    return tab;
  endfunction

  // Encode table: floor(255 * enc(idx / M)), M = 2^LUM_INDEX_BITS - 1.
  // Above the linear toe the largest k with
  // idx^5 * den^12 >= (1000k + 14025)^12 * M^5 is searched.
  function automatic enc_tab_t build_enc_tab();
    enc_tab_t    tab;
    bn_t         den12;
    bn_t         m5;
    bn_t         lhs;
    bn_t         thr [LIN_DEPTH];
    logic [63:0] m;
    logic [PIX_W:0] lo;
    logic [PIX_W:0] hi;
    logic [PIX_W:0] mid;
    m     = IDX_MAX;
    den12 = bn_pow(bn_t'(ENC_DEN), 12);
    m5    = bn_pow(bn_t'(m), 5);
    for (int k = 0; k < LIN_DEPTH; k++) begin
      thr[k] = bn_pow(bn_t'(ENC_STEP * 64'(k) + ENC_OFS), 12) * m5;
    end
    for (int idx = 0; idx < ENC_DEPTH; idx++) begin
      if (64'(idx) * 64'd10000000 <= 64'd31308 * m) begin
        tab[idx] = PIX_W'((64'd32946 * 64'(idx)) / ENC_TOE_DEN);
      end else begin
        lhs = bn_pow(bn_t'(idx), 5) * den12;
        lo  = '0;
        hi  = (PIX_W+1)'(GRAY_MAX);
        while (lo < hi) begin
          mid = (lo + hi + 1'b1) >> 1;
          if (lhs >= thr[mid[PIX_W-1:0]]) begin
            lo = mid;
          end else begin
            hi = mid - 1'b1;
          end
        end
        tab[idx] = lo[PIX_W-1:0];
      end
    end
    return tab;
  endfunction

  localparam lin_tab_t LIN_TAB = build_lin_tab();
  localparam enc_tab_t ENC_TAB = build_enc_tab();

endpackage

`default_nettype wire

>>> src/s2gl_if.sv
// ----------------------------------------------------------------------------
// s2gl_if: pixel and gray channels
// Valid/ready channels carrying one RGB pixel word in and one gray word out.
// ----------------------------------------------------------------------------
`default_nettype none

interface s2gl_in_if;
  logic                valid;
  logic                ready;
  s2gl_pkg::pix_t      red;
  s2gl_pkg::pix_t      green;
  s2gl_pkg::pix_t      blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface s2gl_out_if;
  logic                valid;
  logic                ready;
  s2gl_pkg::pix_t      gray;

  modport source (output valid, gray, input ready);
  modport sink   (input valid, gray, output ready);
endinterface

`default_nettype wire

>>> src/s2gl_enc_rom.sv
// ----------------------------------------------------------------------------
// s2gl_enc_rom: luminance encode ROM
// Maps a luminance index to its sRGB encoded gray level, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module s2gl_enc_rom (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire s2gl_pkg::idx_t idx,
  output s2gl_pkg::pix_t      gray
);

  s2gl_pkg::pix_t gray_r;

  always_ff @(posedge clk) begin
    if (en) begin
      gray_r <= s2gl_pkg::ENC_TAB[idx];
    end
  end

  assign gray = gray_r;

endmodule

`default_nettype wire

>>> src/srgb_to_gray_luminance.sv
// ----------------------------------------------------------------------------
// srgb_to_gray_luminance: sRGB pixel to gray by Rec.709 luminance
// Four-stage pipeline: input register, sRGB linearize lookup, weighted
// luminance sum, and encode ROM read into the output register.
// ----------------------------------------------------------------------------
// Usage:
// A pixel word (red, green, blue, each an 8-bit sRGB code) enters on in_pix
// when valid and ready are both high. One gray word leaves on out_pix for
// every pixel, in order, when its valid and ready are both high.
// A word passes from acceptance through the stage 1, stage 2, stage 3 and
// output registers to out_pix. Throughput is one pixel per clock while the
// receiver takes words: each stage holds one word and passes it on in the
// next cycle, and the encode ROM has one read port that is read once per word.
// Each stage moves whenever it is empty or the stage after it moves, so when
// the receiver stalls the pipeline keeps filling its empty stages and
// in_pix.ready drops only once all four stages hold a word.
// Synchronous reset (rst_n low) empties the pipeline; words in flight are
// dropped. The tables are constants and need no loading after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module srgb_to_gray_luminance (
  input  wire logic clk,
  input  wire logic rst_n,
  s2gl_in_if.sink   in_pix,
  s2gl_out_if.source out_pix
);

  // Stage valid flags.
  logic s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  logic s1_valid_nxt, s2_valid_nxt, s3_valid_nxt, out_valid_nxt;

  // Per-stage advance: a stage takes a new word when it is empty or its
  // current word moves on in the same cycle.
  logic s1_adv, s2_adv, s3_adv, out_adv;

  // Stage 1: registered pixel.
  s2gl_pkg::pix_t red_r, green_r, blue_r;

  // Stage 2: linear channel values.
  s2gl_pkg::lin_t red_lin_r, green_lin_r, blue_lin_r;

  // Stage 3: luminance index.
  logic [s2gl_pkg::SUM_W-1:0] lum_sum;
  s2gl_pkg::idx_t             idx_r;
  s2gl_pkg::idx_t             idx_nxt;

  assign out_adv = !out_valid_r || out_pix.ready;
  assign s3_adv  = !s3_valid_r  || out_adv;
  assign s2_adv  = !s2_valid_r  || s3_adv;
  assign s1_adv  = !s1_valid_r  || s2_adv;

  assign in_pix.ready = s1_adv;

  assign s1_valid_nxt  = s1_adv  ? in_pix.valid : s1_valid_r;
  assign s2_valid_nxt  = s2_adv  ? s1_valid_r   : s2_valid_r;
  assign s3_valid_nxt  = s3_adv  ? s2_valid_r   : s3_valid_r;
  assign out_valid_nxt = out_adv ? s3_valid_r   : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      s3_valid_r  <= s3_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Stage 1: capture the pixel.
  always_ff @(posedge clk) begin
    if (s1_adv && in_pix.valid) begin
      red_r   <= in_pix.red;
      green_r <= in_pix.green;
      blue_r  <= in_pix.blue;
    end
  end

  // Stage 2: undo the sRGB transfer curve with the 256-entry table.
  always_ff @(posedge clk) begin
    if (s2_adv && s1_valid_r) begin
      red_lin_r   <= s2gl_pkg::LIN_TAB[red_r];
      green_lin_r <= s2gl_pkg::LIN_TAB[green_r];
      blue_lin_r  <= s2gl_pkg::LIN_TAB[blue_r];
    end
  end

  // Stage 3: Q0.16 weighted sum. The weights add up to 2^16, so the sum of
  // three 16-bit values fits in 32 bits and its top half is the luminance.
  assign lum_sum = s2gl_pkg::SUM_W'(red_lin_r)   * s2gl_pkg::SUM_W'(s2gl_pkg::R_WEIGHT)
                 + s2gl_pkg::SUM_W'(green_lin_r) * s2gl_pkg::SUM_W'(s2gl_pkg::G_WEIGHT)
                 + s2gl_pkg::SUM_W'(blue_lin_r)  * s2gl_pkg::SUM_W'(s2gl_pkg::B_WEIGHT);

  assign idx_nxt = lum_sum[s2gl_pkg::SUM_W-1 -: s2gl_pkg::LUM_INDEX_BITS];

  always_ff @(posedge clk) begin
    if (s3_adv && s2_valid_r) begin
      idx_r <= idx_nxt;
    end
  end

  // Stage 4: encode ROM read lands directly in the output register.
  s2gl_enc_rom u_enc_rom (
    .clk  (clk),
    .en   (out_adv && s3_valid_r),
    .idx  (idx_r),
    .gray (out_pix.gray)
  );

  assign out_pix.valid = out_valid_r;

endmodule

`default_nettype wire

>>> tb/srgb_to_gray_luminance_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srgb_to_gray_luminance_tb: self-checking bench for the sRGB to gray block
// Pixel words are driven in random bursts while the gray channel stalls on
// its own pattern. Every accepted pixel is turned into an expected gray
// level by an independent model with exactly computed curve tables, and
// each gray word that leaves the block is checked against it, in order.
// ----------------------------------------------------------------------------

module srgb_to_gray_luminance_tb;
  typedef s2gl_pkg::pix_t pix_t;

  // Width of the luminance index that selects the encode curve entry.
  localparam int IDX_BITS = 12;
  localparam int IDX_TOP  = (1 << IDX_BITS) - 1;
  // Q0.16 Rec.709 weights for R, G and B.
  localparam longint unsigned WR = 13933;
  localparam longint unsigned WG = 46871;
  localparam longint unsigned WB = 4732;
  // 1.055 * 255000: denominator of the power-law segment of both curves.
  localparam int CURVE_DEN = 269025;
  localparam int DIRECT_LIMIT = 1200;

  typedef logic [319:0] wide_t;

  typedef struct packed {
    pix_t red;
    pix_t green;
    pix_t blue;
  } rgb_word_t;

  // The receiver switches between these stall behaviors at random times,
  // so that stalls land on every pipeline phase.
  typedef enum int {RX_OPEN, RX_COIN, RX_CADENCE, RX_LONG} rx_mode_e;

  logic clk;
  logic rst_n;

  s2gl_in_if  pix_if ();
  s2gl_out_if gray_if ();

  srgb_to_gray_luminance dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (pix_if.sink),
    .out_pix (gray_if.source)
  );

  // Curves of the model: the linear light value of each sRGB code and the
  // sRGB gray level of each luminance index.
  logic [15:0] lin_curve [256];
  pix_t        gamma_rom [1 << IDX_BITS];

  rgb_word_t pixel_queue [$];
  pix_t      gray_expect [$];

  int       mismatches;
  int       burst_left;
  int       gap_left;
  rx_mode_e rx_mode;
  int       rx_left;
  int       rx_hold;
  pix_t     gray_want;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic wide_t wide_power(wide_t base, int n);
    wide_t acc;
    acc = wide_t'(1);
    for (int i = 0; i < n; i++) begin
      acc = acc * base;
    end
    return acc;
  endfunction

  // Both curves are first estimated in floating point and then moved to the
  // exact boundary with integer comparisons, all terms raised to the powers
  // that clear the 2.4 exponent (12/5) so that no rounding is involved.
  task automatic build_curves();
    wide_t den_pow12;
    wide_t lin_scale;
    wide_t a_term;
    wide_t idx_term;
    wide_t m_pow5;
    wide_t thr [256];
    real   ratio;
    int    y;
    int    k;
    den_pow12 = wide_power(wide_t'(CURVE_DEN), 12);
    lin_scale = wide_t'(32) * wide_power(wide_t'(65535), 5);
    for (int c = 0; c < 256; c++) begin
      if (c <= 10) begin
        // Linear toe: round(65535 * c / (255 * 12.92)).
        lin_curve[c] = 16'((64'd1310700 * 64'(c) + 64'd32946) / 64'd65892);
      end else begin
        // y is the largest code with y - 1/2 <= 65535 * (a / den)^2.4.
        a_term = lin_scale * wide_power(wide_t'(1000 * c + 14025), 12);
        ratio  = (1000.0 * c + 14025.0) / CURVE_DEN;
        y      = $rtoi($floor(65535.0 * $pow(ratio, 2.4) + 0.5));
        if (y < 1) y = 1;
        if (y > 65535) y = 65535;
        while (y < 65535 && wide_power(wide_t'(2 * y + 1), 5) * den_pow12 <= a_term) y++;
        while (y > 1 && wide_power(wide_t'(2 * y - 1), 5) * den_pow12 > a_term) y--;
        lin_curve[c] = 16'(y);
      end
    end
    m_pow5 = wide_power(wide_t'(IDX_TOP), 5);
    for (int g = 0; g < 256; g++) begin
      thr[g] = wide_power(wide_t'(1000 * g + 14025), 12) * m_pow5;
    end
    for (int idx = 0; idx <= IDX_TOP; idx++) begin
      if (longint'(idx) * 10000000 <= 31308 * longint'(IDX_TOP)) begin
        // Linear toe of the encode curve: floor(255 * 12.92 * idx / M).
        gamma_rom[idx] = pix_t'((32946 * longint'(idx)) / (10 * longint'(IDX_TOP)));
      end else begin
        // Largest gray level k whose threshold idx^5 * den^12 still reaches.
        idx_term = wide_power(wide_t'(idx), 5) * den_pow12;
        k = $rtoi($floor(255.0 * (1.055 * $pow(real'(idx) / IDX_TOP, 1.0 / 2.4) - 0.055)));
        if (k < 0) k = 0;
        if (k > 255) k = 255;
        while (k < 255 && idx_term >= thr[k + 1]) k++;
        while (k > 0 && idx_term < thr[k]) k--;
        gamma_rom[idx] = pix_t'(k);
      end
    end
  endtask

  // Gray level of one pixel: linearize, weight, keep the top index bits,
  // re-encode.
  function automatic pix_t luma_to_gray(rgb_word_t px);
    longint unsigned lum;
    lum = (WR * lin_curve[px.red] + WG * lin_curve[px.green]
           + WB * lin_curve[px.blue]) >> 16;
    return gamma_rom[lum >> (16 - IDX_BITS)];
  endfunction

  // Sender. A word stays on the bus until it is taken; once it is, the next
  // one goes up at once inside a burst, or after a random gap between
  // bursts. The expectation is queued at the edge that accepts the word.
  always @(posedge clk) begin
    if (!rst_n) begin
      pix_if.valid <= 1'b0;
      burst_left = $urandom_range(1, 40);
      gap_left   = 0;
    end else begin
      if (pix_if.valid && pix_if.ready) begin
        gray_expect.push_back(luma_to_gray(pixel_queue.pop_front()));
      end
      if (!pix_if.valid || pix_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          pix_if.valid <= 1'b0;
        end else if (pixel_queue.size() != 0) begin
          pix_if.valid <= 1'b1;
          pix_if.red   <= pixel_queue[0].red;
          pix_if.green <= pixel_queue[0].green;
          pix_if.blue  <= pixel_queue[0].blue;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            // A third of the bursts run straight into the next one.
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          pix_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern.
  always @(posedge clk) begin
    if (!rst_n) begin
      gray_if.ready <= 1'b0;
      rx_left = 0;
      rx_hold = 0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(16, 96);
      end
      rx_left--;
      case (rx_mode)
        RX_OPEN: begin
          gray_if.ready <= 1'b1;
        end
        RX_COIN: begin
          gray_if.ready <= 1'($urandom_range(0, 1));
        end
        RX_CADENCE: begin
          gray_if.ready <= (rx_left % 3) != 0;
        end
        default: begin
          // Mostly open, with occasional long stalls that fill the pipeline.
          if (rx_hold > 0) begin
            rx_hold--;
            gray_if.ready <= 1'b0;
          end else if ($urandom_range(0, 7) == 0) begin
            rx_hold = $urandom_range(2, 12);
            gray_if.ready <= 1'b0;
          end else begin
            gray_if.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // Checker: each gray word taken is compared with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && gray_if.valid && gray_if.ready) begin
      if (gray_expect.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("gray word %0d arrived with no pixel outstanding", gray_if.gray);
        end
      end else begin
        gray_want = gray_expect.pop_front();
        if (gray_if.gray !== gray_want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("gray mismatch: expected %0d, got %0d", gray_want, gray_if.gray);
          end
        end
      end
    end
  end

  initial begin
    rgb_word_t px;
    rst_n         = 1'b0;
    pix_if.valid  = 1'b0;
    pix_if.red    = '0;
    pix_if.green  = '0;
    pix_if.blue   = '0;
    gray_if.ready = 1'b0;
    mismatches    = 0;
    build_curves();

    // Directed words: black and white, each primary alone, the last code on
    // the linear toe of the input curve and the first above it, single-code
    // inputs that land on the encode curve's linear toe, and the two green
    // codes whose luminance sits on either side of the encode toe's end.
    pixel_queue.push_back('{8'd0, 8'd0, 8'd0});
    pixel_queue.push_back('{8'd255, 8'd255, 8'd255});
    pixel_queue.push_back('{8'd255, 8'd0, 8'd0});
    pixel_queue.push_back('{8'd0, 8'd255, 8'd0});
    pixel_queue.push_back('{8'd0, 8'd0, 8'd255});
    pixel_queue.push_back('{8'd1, 8'd0, 8'd0});
    pixel_queue.push_back('{8'd0, 8'd1, 8'd0});
    pixel_queue.push_back('{8'd0, 8'd0, 8'd1});
    pixel_queue.push_back('{8'd10, 8'd10, 8'd10});
    pixel_queue.push_back('{8'd11, 8'd11, 8'd11});
    pixel_queue.push_back('{8'd10, 8'd11, 8'd10});
    pixel_queue.push_back('{8'd0, 8'd14, 8'd0});
    pixel_queue.push_back('{8'd0, 8'd15, 8'd0});
    pixel_queue.push_back('{8'd20, 8'd13, 8'd40});
    pixel_queue.push_back('{8'd128, 8'd128, 8'd128});
    pixel_queue.push_back('{8'd254, 8'd254, 8'd254});
    pixel_queue.push_back('{8'd0, 8'd255, 8'd255});
    pixel_queue.push_back('{8'd255, 8'd0, 8'd255});
    pixel_queue.push_back('{8'd255, 8'd255, 8'd0});
    pixel_queue.push_back('{8'd170, 8'd85, 8'd170});
    pixel_queue.push_back('{8'd85, 8'd170, 8'd85});

    // Random words: dark pixels near both toes, neutral grays, channels
    // pinned at the extremes, and plain uniform pixels.
    for (int n = 0; n < DIRECT_LIMIT; n++) begin
      case ($urandom_range(0, 5))
        0: begin
          px.red   = pix_t'($urandom_range(0, 24));
          px.green = pix_t'($urandom_range(0, 24));
          px.blue  = pix_t'($urandom_range(0, 24));
        end
        1: begin
          px.red   = pix_t'($urandom_range(0, 255));
          px.green = px.red;
          px.blue  = px.red;
        end
        2: begin
          px.red   = ($urandom_range(0, 2) == 0) ? pix_t'($urandom_range(0, 255))
                                                 : {8{1'($urandom_range(0, 1))}};
          px.green = ($urandom_range(0, 2) == 0) ? pix_t'($urandom_range(0, 255))
                                                 : {8{1'($urandom_range(0, 1))}};
          px.blue  = ($urandom_range(0, 2) == 0) ? pix_t'($urandom_range(0, 255))
                                                 : {8{1'($urandom_range(0, 1))}};
        end
        default: begin
          px = rgb_word_t'($urandom);
        end
      endcase
      pixel_queue.push_back(px);
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: every pixel taken and every gray word back, then the clock runs on
    // so that a stray extra word would still be caught.
    while (pixel_queue.size() != 0 || gray_expect.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatches == 0 && gray_expect.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog. The slowest legal run is well under half a millisecond.
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
